>>> hdl/dstwr_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the two-way ranging responder sequencer.
// Depends on nothing; imported by all modules and the testbench.

package dstwr_pkg;

   // Codes of the action field.
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_RESET = 2'd1;
   localparam logic [1:0] ACT_TX    = 2'd2;
   localparam logic [1:0] ACT_RXON  = 2'd3;

   // Codes of the reset_reason field.
   localparam logic [2:0] WHY_NONE    = 3'd0;
   localparam logic [2:0] WHY_TIMEOUT = 3'd1;
   localparam logic [2:0] WHY_STATUS  = 3'd2;
   localparam logic [2:0] WHY_TYPE    = 3'd3;
   localparam logic [2:0] WHY_TXFAIL  = 3'd4;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 40;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RETRY_LIMIT  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPLY_DELAY  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_POLL   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_POLL  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESPONSE     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FINAL        = 3'd5;

   // Register values after reset.
   localparam logic [15:0] RETRY_LIMIT_RESET  = 16'd20000;
   localparam logic [39:0] REPLY_DELAY_RESET  = 40'd63897600;
   localparam logic [7:0]  FIRST_POLL_RESET   = 8'hA1;
   localparam logic [7:0]  SECOND_POLL_RESET  = 8'hA2;
   localparam logic [7:0]  RESPONSE_RESET     = 8'hB2;
   localparam logic [7:0]  FINAL_RESET        = 8'hA3;

   // Number of low transmit-time bits that the radio ignores.
   localparam int unsigned SLOT_BITS = 9;

   localparam int unsigned RETRY_BITS = 17;

   // Session codes as reported in session_state.
   localparam logic [2:0] SESS_WAIT_POLL     = 3'd0;
   localparam logic [2:0] SESS_SEND_RESPONSE = 3'd1;
   localparam logic [2:0] SESS_WAIT_RESP_TX  = 3'd2;
   localparam logic [2:0] SESS_WAIT_POLL2    = 3'd3;
   localparam logic [2:0] SESS_SEND_FINAL    = 3'd4;
   localparam logic [2:0] SESS_WAIT_FINAL_TX = 3'd5;

   typedef enum logic [5:0] {
      ST_WAIT_POLL     = 6'b000001,
      ST_SEND_RESPONSE = 6'b000010,
      ST_WAIT_RESP_TX  = 6'b000100,
      ST_WAIT_POLL2    = 6'b001000,
      ST_SEND_FINAL    = 6'b010000,
      ST_WAIT_FINAL_TX = 6'b100000
   } state_type;

   typedef struct packed {
      logic [15:0] retry_limit;
      logic [39:0] reply_delay_ticks;
      logic [7:0]  first_poll_type;
      logic [7:0]  second_poll_type;
      logic [7:0]  response_type;
      logic [7:0]  final_type;
   } cfg_type;

   typedef struct packed {
      logic        event_pending;
      logic        rx_data_ready;
      logic        rx_crc_good;
      logic        leading_edge_done;
      logic        tx_frame_sent;
      logic [7:0]  rx_msg_type;
      logic [39:0] rx_timestamp;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  reset_reason;
      logic [39:0] tx_time;
      logic [39:0] reply_interval;
      logic [7:0]  tx_msg_type;
      logic [2:0]  session_state;
   } rsp_type;

   function automatic logic [2:0] state_code(input state_type st);
      logic [2:0] code;
      case (st)
         ST_SEND_RESPONSE: code = SESS_SEND_RESPONSE;
         ST_WAIT_RESP_TX:  code = SESS_WAIT_RESP_TX;
         ST_WAIT_POLL2:    code = SESS_WAIT_POLL2;
         ST_SEND_FINAL:    code = SESS_SEND_FINAL;
         ST_WAIT_FINAL_TX: code = SESS_WAIT_FINAL_TX;
         default:          code = SESS_WAIT_POLL;
      endcase
      return code;
   endfunction

endpackage

>>> hdl/dstwr_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the ranging responder sequencer.
// Plain valid/ready channels; no dependencies.

interface dstwr_req_if;
   logic        valid;
   logic        ready;
   logic        event_pending;
   logic        rx_data_ready;
   logic        rx_crc_good;
   logic        leading_edge_done;
   logic        tx_frame_sent;
   logic [7:0]  rx_msg_type;
   logic [39:0] rx_timestamp;

   modport source (
      output valid, event_pending, rx_data_ready, rx_crc_good, leading_edge_done,
             tx_frame_sent, rx_msg_type, rx_timestamp,
      input  ready
   );
   modport sink (
      input  valid, event_pending, rx_data_ready, rx_crc_good, leading_edge_done,
             tx_frame_sent, rx_msg_type, rx_timestamp,
      output ready
   );
endinterface

interface dstwr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [2:0]  reset_reason;
   logic [39:0] tx_time;
   logic [39:0] reply_interval;
   logic [7:0]  tx_msg_type;
   logic [2:0]  session_state;

   modport source (
      output valid, action, reset_reason, tx_time, reply_interval, tx_msg_type,
             session_state,
      input  ready
   );
   modport sink (
      input  valid, action, reset_reason, tx_time, reply_interval, tx_msg_type,
             session_state,
      output ready
   );
endinterface

>>> hdl/dstwr_step.sv
`timescale 1ns / 1ps
// Next-state and result logic of one scheduler call of the ranging responder.
// Depends on dstwr_pkg.

module dstwr_step import dstwr_pkg::*; #(
   parameter int unsigned TIME_BITS = 40
) (
   input  state_type              state_ff,
   input  logic [RETRY_BITS-1:0]  retry_ff,
   input  logic [TIME_BITS-1:0]   first_rx_ff,
   input  logic [TIME_BITS-1:0]   second_rx_ff,
   input  cfg_type                cfg,
   input  req_type                req,
   output state_type              state_in,
   output logic [RETRY_BITS-1:0]  retry_in,
   output logic [TIME_BITS-1:0]   first_rx_in,
   output logic [TIME_BITS-1:0]   second_rx_in,
   output rsp_type                rsp
);

   logic [TIME_BITS-1:0]  sched_rx;
   logic [TIME_BITS-1:0]  delay_t;
   logic [TIME_BITS-1:0]  rx_ts_t;
   logic [TIME_BITS-1:0]  sum_t;
   logic [TIME_BITS-1:0]  tx_t;
   logic [TIME_BITS-1:0]  interval_t;
   logic [RETRY_BITS-1:0] retry_inc;
   logic                  timed_out;
   logic                  status_ok;

   assign delay_t  = TIME_BITS'(cfg.reply_delay_ticks);
   assign rx_ts_t  = TIME_BITS'(req.rx_timestamp);
   assign sched_rx = (state_ff == ST_SEND_FINAL) ? second_rx_ff : first_rx_ff;
   assign sum_t    = sched_rx + delay_t;
   // The radio schedules on 512-tick slots, so the low bits are dropped.
   assign tx_t       = {sum_t[TIME_BITS-1:SLOT_BITS], {SLOT_BITS{1'b0}}};
   assign interval_t = tx_t - sched_rx;

   assign retry_inc = retry_ff + 1'b1;
   assign timed_out = retry_inc > {1'b0, cfg.retry_limit};
   assign status_ok = req.rx_data_ready & req.rx_crc_good & req.leading_edge_done;

   always_comb begin
      state_type next_st;
      next_st        = state_ff;
      retry_in       = retry_ff;
      first_rx_in    = first_rx_ff;
      second_rx_in   = second_rx_ff;
      rsp            = '0;
      rsp.action     = ACT_NONE;
      rsp.reset_reason = WHY_NONE;

      case (state_ff)
         ST_SEND_RESPONSE, ST_SEND_FINAL: begin
            rsp.action         = ACT_TX;
            rsp.tx_time        = 40'(tx_t);
            rsp.reply_interval = 40'(interval_t);
            retry_in           = '0;
            if (state_ff == ST_SEND_FINAL) begin
               rsp.tx_msg_type = cfg.final_type;
               next_st         = ST_WAIT_FINAL_TX;
            end else begin
               rsp.tx_msg_type = cfg.response_type;
               next_st         = ST_WAIT_RESP_TX;
            end
         end
         ST_WAIT_RESP_TX, ST_WAIT_FINAL_TX: begin
            if (!req.event_pending) begin
               retry_in = retry_inc;
               if (timed_out) begin
                  rsp.action       = ACT_RESET;
                  rsp.reset_reason = WHY_TIMEOUT;
               end
            end else if (req.tx_frame_sent) begin
               rsp.action = ACT_RXON;
               retry_in   = '0;
               next_st    = (state_ff == ST_WAIT_FINAL_TX) ? ST_WAIT_POLL : ST_WAIT_POLL2;
            end else begin
               rsp.action       = ACT_RESET;
               rsp.reset_reason = WHY_TXFAIL;
            end
         end
         ST_WAIT_POLL2: begin
            if (!req.event_pending) begin
               retry_in = retry_inc;
               if (timed_out) begin
                  rsp.action       = ACT_RESET;
                  rsp.reset_reason = WHY_TIMEOUT;
               end
            end else if (!status_ok) begin
               rsp.action       = ACT_RESET;
               rsp.reset_reason = WHY_STATUS;
            end else if (req.rx_msg_type != cfg.second_poll_type) begin
               rsp.action       = ACT_RESET;
               rsp.reset_reason = WHY_TYPE;
            end else begin
               second_rx_in = rx_ts_t;
               retry_in     = '0;
               next_st      = ST_SEND_FINAL;
            end
         end
         default: begin
            // Waiting for the first poll; any unknown code behaves the same.
            next_st = ST_WAIT_POLL;
            if (!req.event_pending) begin
               retry_in = retry_inc;
               if (timed_out) begin
                  rsp.action       = ACT_RESET;
                  rsp.reset_reason = WHY_TIMEOUT;
               end
            end else if (!status_ok) begin
               rsp.action       = ACT_RESET;
               rsp.reset_reason = WHY_STATUS;
            end else if (req.rx_msg_type != cfg.first_poll_type) begin
               rsp.action       = ACT_RESET;
               rsp.reset_reason = WHY_TYPE;
            end else begin
               first_rx_in = rx_ts_t;
               retry_in    = '0;
               next_st     = ST_SEND_RESPONSE;
            end
         end
      endcase

      // Every fault or timeout ends the session and forgets both receive times.
      if (rsp.action == ACT_RESET) begin
         next_st      = ST_WAIT_POLL;
         retry_in     = '0;
         first_rx_in  = '0;
         second_rx_in = '0;
      end

      state_in          = next_st;
      rsp.session_state = state_code(next_st);
   end

endmodule

>>> hdl/ds_twr_responder_sequencer.sv
`timescale 1ns / 1ps
// Top level of the double-sided two-way ranging responder sequencer.
// Depends on dstwr_pkg, dstwr_if.sv and dstwr_step.
//
// Usage: each request on req_ch is one scheduler call carrying the radio
// event flag, status bits, received type byte and 40-bit receive timestamp.
// Each request produces exactly one result on rsp_ch: the action to take
// (none, session reset, delayed transmit, receive re-enable), the reason of a
// reset, the delayed transmit time and reply interval on a send step, the
// type byte to transmit and the session state after the call.
// The result is registered. Throughput is one request per cycle unless
// stalled; the session state update is a single pass through one 40-bit
// add and subtract and the retry compare. The result register stalls the
// request side only while a result is held and rsp_ch.ready is low; then
// req_ch.ready is low and nothing is lost. Reset (synchronous, active high)
// returns the session to waiting for the first poll, clears the retry count
// and stored times, loads the register defaults and empties the result
// register. Registers are written through csr_we / csr_index / csr_wdata
// while the block is idle; the user must ensure it, the block does not.

module ds_twr_responder_sequencer import dstwr_pkg::*; #(
   parameter int unsigned TIME_BITS = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   dstwr_req_if.sink                 req_ch,
   dstwr_rsp_if.source               rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type               cfg_ff;
   state_type             state_ff, state_in;
   logic [RETRY_BITS-1:0] retry_ff, retry_in;
   logic [TIME_BITS-1:0]  first_rx_ff, first_rx_in;
   logic [TIME_BITS-1:0]  second_rx_ff, second_rx_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   req_type               req_word;
   logic                  req_take;

   assign req_word.event_pending     = req_ch.event_pending;
   assign req_word.rx_data_ready     = req_ch.rx_data_ready;
   assign req_word.rx_crc_good       = req_ch.rx_crc_good;
   assign req_word.leading_edge_done = req_ch.leading_edge_done;
   assign req_word.tx_frame_sent     = req_ch.tx_frame_sent;
   assign req_word.rx_msg_type       = req_ch.rx_msg_type;
   assign req_word.rx_timestamp      = req_ch.rx_timestamp;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   dstwr_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .state_ff     (state_ff),
      .retry_ff     (retry_ff),
      .first_rx_ff  (first_rx_ff),
      .second_rx_ff (second_rx_ff),
      .cfg          (cfg_ff),
      .req          (req_word),
      .state_in     (state_in),
      .retry_in     (retry_in),
      .first_rx_in  (first_rx_in),
      .second_rx_in (second_rx_in),
      .rsp          (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit       <= RETRY_LIMIT_RESET;
         cfg_ff.reply_delay_ticks <= REPLY_DELAY_RESET;
         cfg_ff.first_poll_type   <= FIRST_POLL_RESET;
         cfg_ff.second_poll_type  <= SECOND_POLL_RESET;
         cfg_ff.response_type     <= RESPONSE_RESET;
         cfg_ff.final_type        <= FINAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RETRY_LIMIT: cfg_ff.retry_limit       <= csr_wdata[15:0];
            CSR_REPLY_DELAY: cfg_ff.reply_delay_ticks <= csr_wdata[39:0];
            CSR_FIRST_POLL:  cfg_ff.first_poll_type   <= csr_wdata[7:0];
            CSR_SECOND_POLL: cfg_ff.second_poll_type  <= csr_wdata[7:0];
            CSR_RESPONSE:    cfg_ff.response_type     <= csr_wdata[7:0];
            CSR_FINAL:       cfg_ff.final_type        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT_POLL;
         retry_ff     <= '0;
         first_rx_ff  <= '0;
         second_rx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff     <= state_in;
            retry_ff     <= retry_in;
            first_rx_ff  <= first_rx_in;
            second_rx_ff <= second_rx_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.action         = rsp_ff.action;
   assign rsp_ch.reset_reason   = rsp_ff.reset_reason;
   assign rsp_ch.tx_time        = rsp_ff.tx_time;
   assign rsp_ch.reply_interval = rsp_ff.reply_interval;
   assign rsp_ch.tx_msg_type    = rsp_ff.tx_msg_type;
   assign rsp_ch.session_state  = rsp_ff.session_state;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the two-way ranging responder sequencer.
// Depends on dstwr_pkg, the channel interfaces in dstwr_if.sv and the RTL top.

module tb_top import dstwr_pkg::*; ();

   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned RANDOM_PER_SETTING = 200;
   localparam int unsigned TIMEOUT_LIMIT = 100;
   localparam int unsigned TIMEOUT_RUN = TIMEOUT_LIMIT + 2;

   // Tracks the responder session and holds the results still owed by the block.
   class ranging_scoreboard;
      cfg_type     regs;
      logic [2:0]  sess;
      logic [16:0] idle_calls;
      logic [39:0] poll1_time;
      logic [39:0] poll2_time;
      rsp_type     owed_results[$];
      int unsigned errors;
      int unsigned requests;
      int unsigned results;
      int unsigned transmits;
      int unsigned rx_enables;
      int unsigned resets_by[5];

      function new();
         regs.retry_limit       = RETRY_LIMIT_RESET;
         regs.reply_delay_ticks = REPLY_DELAY_RESET;
         regs.first_poll_type   = FIRST_POLL_RESET;
         regs.second_poll_type  = SECOND_POLL_RESET;
         regs.response_type     = RESPONSE_RESET;
         regs.final_type        = FINAL_RESET;
         sess       = SESS_WAIT_POLL;
         idle_calls = '0;
         poll1_time = '0;
         poll2_time = '0;
         errors     = 0;
         requests   = 0;
         results    = 0;
         transmits  = 0;
         rx_enables = 0;
         foreach (resets_by[i]) resets_by[i] = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_RETRY_LIMIT: regs.retry_limit       = val[15:0];
            CSR_REPLY_DELAY: regs.reply_delay_ticks = val;
            CSR_FIRST_POLL:  regs.first_poll_type   = val[7:0];
            CSR_SECOND_POLL: regs.second_poll_type  = val[7:0];
            CSR_RESPONSE:    regs.response_type     = val[7:0];
            CSR_FINAL:       regs.final_type        = val[7:0];
            default: ;
         endcase
      endfunction

      function void drop_session(inout rsp_type o, input logic [2:0] why);
         sess       = SESS_WAIT_POLL;
         idle_calls = '0;
         poll1_time = '0;
         poll2_time = '0;
         o.action       = ACT_RESET;
         o.reset_reason = why;
         resets_by[why]++;
      endfunction

      function void count_idle(inout rsp_type o);
         idle_calls = idle_calls + 17'd1;
         if (idle_calls > {1'b0, regs.retry_limit})
            drop_session(o, WHY_TIMEOUT);
      endfunction

      // Status bits are checked before the type byte.
      function bit frame_good(req_type r, logic [7:0] want, inout rsp_type o);
         if (!(r.rx_data_ready && r.rx_crc_good && r.leading_edge_done)) begin
            drop_session(o, WHY_STATUS);
            return 1'b0;
         end
         if (r.rx_msg_type != want) begin
            drop_session(o, WHY_TYPE);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void launch(inout rsp_type o, input logic [39:0] rx_at, input logic [7:0] kind,
                           input logic [2:0] next);
         logic [39:0] at;
         at = rx_at + regs.reply_delay_ticks;
         at[SLOT_BITS-1:0] = '0;
         o.action         = ACT_TX;
         o.tx_time        = at;
         o.reply_interval = at - rx_at;
         o.tx_msg_type    = kind;
         sess       = next;
         idle_calls = '0;
         transmits++;
      endfunction

      function void sent_wait(req_type r, inout rsp_type o, input logic [2:0] next);
         if (!r.event_pending) begin
            count_idle(o);
         end else if (r.tx_frame_sent) begin
            o.action   = ACT_RXON;
            sess       = next;
            idle_calls = '0;
            rx_enables++;
         end else begin
            drop_session(o, WHY_TXFAIL);
         end
      endfunction

      function void note_request(req_type r);
         rsp_type o;
         o = '0;
         o.action = ACT_NONE;
         case (sess)
            SESS_SEND_RESPONSE: launch(o, poll1_time, regs.response_type, SESS_WAIT_RESP_TX);
            SESS_WAIT_RESP_TX:  sent_wait(r, o, SESS_WAIT_POLL2);
            SESS_WAIT_POLL2: begin
               if (!r.event_pending) begin
                  count_idle(o);
               end else if (frame_good(r, regs.second_poll_type, o)) begin
                  poll2_time = r.rx_timestamp;
                  idle_calls = '0;
                  sess       = SESS_SEND_FINAL;
               end
            end
            SESS_SEND_FINAL:    launch(o, poll2_time, regs.final_type, SESS_WAIT_FINAL_TX);
            SESS_WAIT_FINAL_TX: sent_wait(r, o, SESS_WAIT_POLL);
            default: begin
               sess = SESS_WAIT_POLL;
               if (!r.event_pending) begin
                  count_idle(o);
               end else if (frame_good(r, regs.first_poll_type, o)) begin
                  poll1_time = r.rx_timestamp;
                  idle_calls = '0;
                  sess       = SESS_SEND_RESPONSE;
               end
            end
         endcase
         o.session_state = sess;
         owed_results.push_back(o);
         requests++;
      endfunction

      function void compare_field(string name, logic [39:0] want, logic [39:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results++;
         if (owed_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            return;
         end
         want = owed_results.pop_front();
         compare_field("action", 40'(want.action), 40'(got.action));
         compare_field("reset_reason", 40'(want.reset_reason), 40'(got.reset_reason));
         compare_field("tx_time", want.tx_time, got.tx_time);
         compare_field("reply_interval", want.reply_interval, got.reply_interval);
         compare_field("tx_msg_type", 40'(want.tx_msg_type), 40'(got.tx_msg_type));
         compare_field("session_state", 40'(want.session_state), 40'(got.session_state));
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   dstwr_req_if req_ch();
   dstwr_rsp_if rsp_ch();

   ds_twr_responder_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ranging_scoreboard sb;
   int unsigned       cycles;
   int unsigned       burst_left;
   bit                steady;
   int unsigned       settings_used;
   int unsigned       rsp_mode;
   int unsigned       rsp_stretch;
   int unsigned       rsp_hold;
   int unsigned       rsp_seen;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: checks accepted results and stalls on a pattern of its own,
   // with a few long hold-offs so that the block backs up into the request side.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result({rsp_ch.action, rsp_ch.reset_reason, rsp_ch.tx_time,
                          rsp_ch.reply_interval, rsp_ch.tx_msg_type, rsp_ch.session_state});
         rsp_seen++;
         if (rsp_seen == 400 || rsp_seen == 900 || rsp_seen == 20000)
            rsp_hold = 150;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_stretch == 0) begin
            rsp_mode    = $urandom_range(2);
            rsp_stretch = $urandom_range(20, 200);
         end
         rsp_stretch--;
         case (rsp_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(3) != 0);
            default: rsp_ch.ready <= ($urandom_range(9) < 3);
         endcase
      end
   end

   function automatic logic [39:0] random_time();
      logic [39:0] t;
      case ($urandom_range(7))
         0: t = '0;
         1: t = '1;
         2: begin
            t = '1;
            t[10:0] = 11'($urandom_range(2047));
         end
         default: begin
            t[31:0]  = $urandom();
            t[39:32] = 8'($urandom_range(255));
         end
      endcase
      return t;
   endfunction

   function automatic req_type random_fields();
      req_type r;
      r.event_pending     = 1'($urandom_range(1));
      r.rx_data_ready     = 1'($urandom_range(1));
      r.rx_crc_good       = 1'($urandom_range(1));
      r.leading_edge_done = 1'($urandom_range(1));
      r.tx_frame_sent     = 1'($urandom_range(1));
      r.rx_msg_type       = 8'($urandom_range(255));
      r.rx_timestamp      = random_time();
      return r;
   endfunction

   function automatic req_type frame(logic ev, logic [2:0] rx_bits, logic sent,
                                     logic [7:0] kind, logic [39:0] ts);
      req_type r;
      r.event_pending = ev;
      {r.rx_data_ready, r.rx_crc_good, r.leading_edge_done} = rx_bits;
      r.tx_frame_sent = sent;
      r.rx_msg_type   = kind;
      r.rx_timestamp  = ts;
      return r;
   endfunction

   // Mostly requests that carry the session forward from where it stands,
   // with idle calls, broken frames, failed sends and pure noise mixed in.
   function automatic req_type next_request();
      req_type     r;
      int unsigned pick;
      logic [7:0]  want;
      r = random_fields();
      pick = $urandom_range(99);
      if (pick < 12)
         return r;
      case (sb.sess)
         SESS_WAIT_POLL, SESS_WAIT_POLL2: begin
            want = (sb.sess == SESS_WAIT_POLL) ? sb.regs.first_poll_type
                                                : sb.regs.second_poll_type;
            if (pick < 30) begin
               r.event_pending = 1'b0;
            end else begin
               r.event_pending = 1'b1;
               r.rx_msg_type   = want;
               {r.rx_data_ready, r.rx_crc_good, r.leading_edge_done} = 3'b111;
               if (pick < 38)
                  {r.rx_data_ready, r.rx_crc_good, r.leading_edge_done} =
                     3'($urandom_range(6));
               else if (pick < 44)
                  r.rx_msg_type = want ^ 8'($urandom_range(1, 255));
            end
         end
         SESS_WAIT_RESP_TX, SESS_WAIT_FINAL_TX: begin
            if (pick < 30) begin
               r.event_pending = 1'b0;
            end else begin
               r.event_pending = 1'b1;
               r.tx_frame_sent = (pick >= 38);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic hold_off(int unsigned n);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic issue(req_type r);
      int unsigned gap;
      req_ch.valid             <= 1'b1;
      req_ch.event_pending     <= r.event_pending;
      req_ch.rx_data_ready     <= r.rx_data_ready;
      req_ch.rx_crc_good       <= r.rx_crc_good;
      req_ch.leading_edge_done <= r.leading_edge_done;
      req_ch.tx_frame_sent     <= r.tx_frame_sent;
      req_ch.rx_msg_type       <= r.rx_msg_type;
      req_ch.rx_timestamp      <= r.rx_timestamp;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (steady || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0)
            hold_off(gap);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      hold_off(1);
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic configure(logic [15:0] limit, logic [39:0] delay, logic [7:0] poll1_kind,
                            logic [7:0] poll2_kind, logic [7:0] resp_kind,
                            logic [7:0] final_kind);
      write_csr(CSR_RETRY_LIMIT, 40'(limit));
      write_csr(CSR_REPLY_DELAY, delay);
      write_csr(CSR_FIRST_POLL, 40'(poll1_kind));
      write_csr(CSR_SECOND_POLL, 40'(poll2_kind));
      write_csr(CSR_RESPONSE, 40'(resp_kind));
      write_csr(CSR_FINAL, 40'(final_kind));
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   initial begin
      req_type r;
      logic [39:0] delay;
      cycles        = 0;
      burst_left    = 0;
      steady        = 1'b0;
      settings_used = 1;
      rsp_mode      = 0;
      rsp_stretch   = 0;
      rsp_hold      = 0;
      rsp_seen      = 0;
      sb = new();
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_ch.ready             = 1'b0;
      req_ch.valid             = 1'b0;
      req_ch.event_pending     = 1'b0;
      req_ch.rx_data_ready     = 1'b0;
      req_ch.rx_crc_good       = 1'b0;
      req_ch.leading_edge_done = 1'b0;
      req_ch.tx_frame_sent     = 1'b0;
      req_ch.rx_msg_type       = '0;
      req_ch.rx_timestamp      = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full session at the timestamp extremes, with the second poll forcing a wrap.
      issue(frame(1'b1, 3'b111, 1'b0, FIRST_POLL_RESET, 40'h0));
      issue(frame(1'b1, 3'b000, 1'b1, 8'hFF, '1));
      issue(frame(1'b1, 3'b000, 1'b1, 8'h00, 40'h0));
      issue(frame(1'b1, 3'b111, 1'b0, SECOND_POLL_RESET, '1));
      issue(frame(1'b0, 3'b000, 1'b0, 8'h00, 40'h0));
      issue(frame(1'b1, 3'b111, 1'b1, 8'hFF, '1));
      // Each missing status bit, then a wrong type byte, on the first poll.
      issue(frame(1'b1, 3'b011, 1'b1, FIRST_POLL_RESET, '1));
      issue(frame(1'b1, 3'b101, 1'b1, FIRST_POLL_RESET, '1));
      issue(frame(1'b1, 3'b110, 1'b1, FIRST_POLL_RESET, '1));
      issue(frame(1'b1, 3'b111, 1'b1, 8'hFF, '1));
      // Response that fails to go out.
      issue(frame(1'b1, 3'b111, 1'b0, FIRST_POLL_RESET, 40'h5));
      issue(frame(1'b0, 3'b000, 1'b0, 8'h00, 40'h0));
      issue(frame(1'b1, 3'b111, 1'b0, 8'h00, 40'h0));
      // Idle call while the response is pending, then bad status on the second poll.
      issue(frame(1'b1, 3'b111, 1'b0, FIRST_POLL_RESET, 40'hFF_FFFF_FE00));
      issue(frame(1'b1, 3'b111, 1'b0, 8'h00, 40'h0));
      issue(frame(1'b0, 3'b111, 1'b1, 8'h00, 40'h0));
      issue(frame(1'b1, 3'b000, 1'b1, 8'h00, 40'h0));
      issue(frame(1'b1, 3'b000, 1'b0, SECOND_POLL_RESET, 40'h1234));
      // Wrong type on the second poll, then an idle call in the first wait.
      issue(frame(1'b1, 3'b111, 1'b0, FIRST_POLL_RESET, 40'h80_0000_01FF));
      issue(frame(1'b1, 3'b111, 1'b1, 8'hFF, '1));
      issue(frame(1'b1, 3'b111, 1'b1, 8'h00, 40'h0));
      issue(frame(1'b1, 3'b111, 1'b0, 8'h00, 40'h7F));
      issue(frame(1'b0, 3'b111, 1'b1, 8'hFF, '1));
      drain();

      for (int p = 0; p < 6; p++) begin
         delay = random_time();
         case (p)
            0: configure(16'd1, 40'h0, 8'h00, 8'hFF, 8'h00, 8'hFF);
            1: configure(16'hFFFF, '1, 8'hFF, 8'h00, 8'hFF, 8'h00);
            2: configure(16'd3, delay, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
            3: configure(16'($urandom_range(1, 6)), 40'($urandom_range(1 << 20)), 8'hA5,
                         8'hA5, 8'($urandom_range(255)), 8'($urandom_range(255)));
            4: configure(16'd2, 40'd511, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
            default: configure(16'($urandom_range(1, 65535)), delay,
                               8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
         endcase
         for (int n = 0; n < RANDOM_PER_SETTING; n++)
            issue(next_request());
         drain();
      end

      // Idle calls back to back until the retry count passes a moderate limit.
      configure(16'(TIMEOUT_LIMIT), REPLY_DELAY_RESET, FIRST_POLL_RESET, SECOND_POLL_RESET,
                RESPONSE_RESET, FINAL_RESET);
      steady = 1'b1;
      for (int n = 0; n < TIMEOUT_RUN; n++) begin
         r = random_fields();
         r.event_pending = 1'b0;
         issue(r);
      end
      drain();

      $display("Run covered %0d requests under %0d register settings:",
               sb.requests, settings_used);
      $display("%0d transmits scheduled, %0d receive re-enables.",
               sb.transmits, sb.rx_enables);
      $display("Session resets seen: %0d timeout, %0d bad status, %0d wrong type, %0d %s",
               sb.resets_by[WHY_TIMEOUT], sb.resets_by[WHY_STATUS], sb.resets_by[WHY_TYPE],
               sb.resets_by[WHY_TXFAIL], "send failure.");
      if (sb.errors == 0 && sb.owed_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
